// ===== src/rsd_pkg.sv =====
`default_nettype none
package rsd_pkg;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = $clog2(QDepth);
  localparam int unsigned QCw    = $clog2(QDepth + 1);

  localparam logic [6:0] CountMask = 7'h7f;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_LIT_OVER   = 3'd1;
  localparam logic [2:0] ST_LIT_SHORT  = 3'd2;
  localparam logic [2:0] ST_REP_OVER   = 3'd3;
  localparam logic [2:0] ST_REP_NOVAL  = 3'd4;
  localparam logic [2:0] ST_INCOMPLETE = 3'd5;
  localparam logic [2:0] ST_UNUSED     = 3'd6;

  // one classified input beat as it sits in the queue
  typedef struct packed {
    logic       end_req;
    logic [7:0] data;
    logic       last;
    logic [6:0] count;
    logic       literal;
    logic       count_zero;
  } rsd_item_t;

  typedef struct packed {
    logic full;
    logic valid;
  } rsd_qstat_t;

endpackage
`default_nettype wire

// ===== src/rsd_front.sv =====
`default_nettype none
module rsd_front import rsd_pkg::*; (
  input  wire logic       in_valid,
  input  wire logic       in_req_type,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_last_byte,
  input  wire rsd_qstat_t qstat,
  output logic            in_stall,
  output logic            push,
  output rsd_item_t       item
);

  assign in_stall = qstat.full;
  assign push     = in_valid & ~qstat.full;

  // decode the code-byte fields once here so the back end only updates state
  always_comb begin
    item.end_req    = in_req_type;
    item.data       = in_data_byte;
    item.last       = in_last_byte;
    item.count      = in_data_byte[6:0] & CountMask;
    item.literal    = in_data_byte[7];
    item.count_zero = (in_data_byte[6:0] == 7'd0);
  end

endmodule
`default_nettype wire

// ===== src/rsd_queue.sv =====
`default_nettype none
module rsd_queue import rsd_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire rsd_item_t push_item,
  input  wire logic      pop,
  output rsd_item_t      head_item,
  output rsd_qstat_t     qstat
);

  rsd_item_t          slot_r [QDepth];
  logic [QAw-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [QAw-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [QCw-1:0]     fill_r, fill_nxt;
  logic               do_pop;

  assign do_pop      = pop & (fill_r != '0);
  assign head_item   = slot_r[rd_ptr_r];
  assign qstat.valid = (fill_r != '0);
  assign qstat.full  = (fill_r == QCw'(QDepth));

  always_comb begin
    wr_ptr_nxt = push   ? QAw'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? QAw'(rd_ptr_r + 1'b1) : rd_ptr_r;
    fill_nxt   = fill_r;
    if (push && !do_pop) begin
      fill_nxt = QCw'(fill_r + 1'b1);
    end else if (!push && do_pop) begin
      fill_nxt = QCw'(fill_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

// ===== src/rsd_back.sv =====
`default_nettype none
module rsd_back import rsd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  input  wire logic [15:0] cfg_line_width,
  output logic             cfg_ready,
  input  wire rsd_qstat_t  qstat,
  input  wire rsd_item_t   head_item,
  output logic             pop,
  input  wire logic        out_stall,
  output logic             out_valid,
  output logic             out_sample_valid,
  output logic [7:0]       out_sample_value,
  output logic [6:0]       out_repeat_count,
  output logic             out_line_done,
  output logic [2:0]       out_line_status
);

  localparam logic [1:0] MODE_CODE    = 2'd0;
  localparam logic [1:0] MODE_LITERAL = 2'd1;
  localparam logic [1:0] MODE_VALUE   = 2'd2;
  localparam logic [1:0] MODE_STOPPED = 2'd3;

  logic [15:0] width_r, width_nxt;
  logic [1:0]  mode_r, mode_nxt;
  logic [6:0]  run_r, run_nxt;
  logic [15:0] pix_r, pix_nxt;
  logic [2:0]  err_r, err_nxt;
  logic        extra_r, extra_nxt;

  logic        out_valid_r;
  logic        smp_valid_r, done_r;
  logic [7:0]  value_r;
  logic [6:0]  rep_r;
  logic [2:0]  status_r;

  logic        emit, done, has_result, cfg_wr;
  logic [7:0]  val;
  logic [6:0]  rep;
  logic [2:0]  status;
  logic [6:0]  run_dec;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;
  assign pop       = qstat.valid & (~out_valid_r | ~out_stall);
  assign run_dec   = 7'(run_r - 1'b1);

  always_comb begin
    width_nxt = width_r;
    mode_nxt  = mode_r;
    run_nxt   = run_r;
    pix_nxt   = pix_r;
    err_nxt   = err_r;
    extra_nxt = extra_r;
    emit      = 1'b0;
    val       = 8'd0;
    rep       = 7'd0;
    done      = 1'b0;
    status    = ST_OK;

    if (cfg_wr) begin
      width_nxt = cfg_line_width;
      mode_nxt  = MODE_CODE;
      run_nxt   = 7'd0;
      pix_nxt   = cfg_line_width;
      err_nxt   = ST_OK;
      extra_nxt = 1'b0;
    end else if (pop) begin
      if (!head_item.end_req) begin
        done = head_item.last;
        if (err_r == ST_OK) begin
          unique case (mode_r)
            MODE_CODE: begin
              priority if (pix_r == 16'd0) begin
                extra_nxt = 1'b1;
              end else if (head_item.count_zero) begin
                mode_nxt = MODE_STOPPED;
              end else if ({9'd0, head_item.count} > pix_r) begin
                err_nxt = head_item.literal ? ST_LIT_OVER : ST_REP_OVER;
              end else if (head_item.last) begin
                err_nxt = head_item.literal ? ST_LIT_SHORT : ST_REP_NOVAL;
              end else begin
                pix_nxt  = pix_r - {9'd0, head_item.count};
                run_nxt  = head_item.count;
                mode_nxt = head_item.literal ? MODE_LITERAL : MODE_VALUE;
              end
            end
            MODE_LITERAL: begin
              emit    = 1'b1;
              val     = head_item.data;
              rep     = 7'd1;
              run_nxt = run_dec;
              if (run_dec == 7'd0) begin
                mode_nxt = MODE_CODE;
              end else if (head_item.last) begin
                err_nxt = ST_LIT_SHORT;
              end
            end
            MODE_VALUE: begin
              emit     = 1'b1;
              val      = head_item.data;
              rep      = run_r;
              run_nxt  = 7'd0;
              mode_nxt = MODE_CODE;
            end
            MODE_STOPPED: begin
              extra_nxt = 1'b1;
            end
            default: begin
              mode_nxt = MODE_CODE;
            end
          endcase
        end
      end else begin
        done = 1'b1;
      end

      // status looks at the state left after this beat
      if (done) begin
        priority if (err_nxt != ST_OK) begin
          status = err_nxt;
        end else if (mode_nxt == MODE_LITERAL && run_nxt != 7'd0) begin
          status = ST_LIT_SHORT;
        end else if (mode_nxt == MODE_VALUE) begin
          status = ST_REP_NOVAL;
        end else if (pix_nxt != 16'd0) begin
          status = ST_INCOMPLETE;
        end else if (extra_nxt) begin
          status = ST_UNUSED;
        end else begin
          status = ST_OK;
        end
        mode_nxt  = MODE_CODE;
        run_nxt   = 7'd0;
        pix_nxt   = width_r;
        err_nxt   = ST_OK;
        extra_nxt = 1'b0;
      end
    end
  end

  assign has_result = pop & ~cfg_wr & (emit | done);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= 16'd1;
      mode_r      <= MODE_CODE;
      run_r       <= 7'd0;
      pix_r       <= 16'd1;
      err_r       <= ST_OK;
      extra_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      width_r <= width_nxt;
      mode_r  <= mode_nxt;
      run_r   <= run_nxt;
      pix_r   <= pix_nxt;
      err_r   <= err_nxt;
      extra_r <= extra_nxt;
      if (has_result) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (has_result) begin
      smp_valid_r <= emit;
      value_r     <= val;
      rep_r       <= rep;
      done_r      <= done;
      status_r    <= status;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sample_valid = smp_valid_r;
  assign out_sample_value = value_r;
  assign out_repeat_count = rep_r;
  assign out_line_done    = done_r;
  assign out_line_status  = status_r;

endmodule
`default_nettype wire

// ===== src/rle_scanline_decoder_unit.sv =====
`default_nettype none
// path: an input beat is written into the queue, then its result is
// registered in the result register when the back end pops it
// throughput: one input beat per cycle while out_stall is low, set by the
// decode step in the back end; a four-entry queue lets the front keep taking
// beats while the result register is stalled, until the queue is full
// reset: synchronous active low; empties the queue and the result register,
// sets the line width to 1 and starts a fresh line
module rle_scanline_decoder_unit import rsd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_req_type,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_sample_valid,
  output logic [7:0]       out_sample_value,
  output logic [6:0]       out_repeat_count,
  output logic             out_line_done,
  output logic [2:0]       out_line_status,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_line_width
);

  rsd_item_t  push_item, head_item;
  rsd_qstat_t qstat;
  logic       push, pop;

  rsd_front u_front (
    .in_valid     (in_valid),
    .in_req_type  (in_req_type),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .qstat        (qstat),
    .in_stall     (in_stall),
    .push         (push),
    .item         (push_item)
  );

  rsd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .qstat     (qstat)
  );

  rsd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_line_width   (cfg_line_width),
    .cfg_ready        (cfg_ready),
    .qstat            (qstat),
    .head_item        (head_item),
    .pop              (pop),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_sample_valid (out_sample_valid),
    .out_sample_value (out_sample_value),
    .out_repeat_count (out_repeat_count),
    .out_line_done    (out_line_done),
    .out_line_status  (out_line_status)
  );

endmodule
`default_nettype wire
